/* rtl/core/sarr_pkg.sv */
// Package for the sorted array table: shared word, operation and status types
// and their codes. No dependencies; imported by sorted_array_table_ops_unit.
package sarr_pkg;

    typedef logic [31:0] word_t;
    typedef logic [1:0]  func_t;
    typedef logic [1:0]  status_t;
    typedef logic [4:0]  capacity_t;

    localparam func_t FUNC_INSERT    = 2'd0;
    localparam func_t FUNC_REVERSE   = 2'd1;
    localparam func_t FUNC_PARTITION = 2'd2;
    localparam func_t FUNC_READ      = 2'd3;

    localparam status_t STATUS_DONE  = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam capacity_t CAPACITY_RESET = 5'd16;

endpackage

/* rtl/core/sorted_array_table_ops_unit.sv */
// Sorted array table: a store of signed words with a fill count, operated on
// by a small sequencer around one memory. Depends on sarr_pkg.
//
// Each item is accepted when start is high and busy is low. The block then
// stays busy until its single result has been shown: done is high for exactly
// one cycle and status, count, in_order and read_value are valid in that cycle
// only, so the receiver must take the result there and then; it cannot hold it
// off. A new item may be started in the very cycle in which done is high. All
// work goes through one memory with a single read port (registered read data)
// and a single write port, and one signed comparator shared by the insert walk
// and the order check. Every item ends with an order check: it walks the
// valid entries one at a time through the read port and compares each with
// its predecessor. The capacity register is written through its own
// valid/ready channel, which is always ready; it should only be written while
// the block is idle.
module sorted_array_table_ops_unit #(
    parameter int DEPTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  sarr_pkg::func_t                 func,
    input  sarr_pkg::word_t                 value,
    input  logic [$clog2(DEPTH)-1:0]        index,
    output logic                            done,
    output sarr_pkg::status_t               status,
    output logic [$clog2(DEPTH+1)-1:0]      count,
    output logic                            in_order,
    output sarr_pkg::word_t                 read_value,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  sarr_pkg::capacity_t             cfg_data
);

    import sarr_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_INS_RD    = 4'd1;
    localparam logic [3:0] ST_INS_CMP   = 4'd2;
    localparam logic [3:0] ST_RV_CHK    = 4'd3;
    localparam logic [3:0] ST_RV_LO     = 4'd4;
    localparam logic [3:0] ST_SW_A      = 4'd5;
    localparam logic [3:0] ST_SW_B      = 4'd6;
    localparam logic [3:0] ST_P_CHK     = 4'd7;
    localparam logic [3:0] ST_P_L_RD    = 4'd8;
    localparam logic [3:0] ST_P_L_CMP   = 4'd9;
    localparam logic [3:0] ST_P_H_RD    = 4'd10;
    localparam logic [3:0] ST_P_H_CMP   = 4'd11;
    localparam logic [3:0] ST_RD_CAP    = 4'd12;
    localparam logic [3:0] ST_ORD_RD    = 4'd13;
    localparam logic [3:0] ST_ORD_CMP   = 4'd14;

    // Control state.
    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] top_reg, top_next;
    capacity_t        capacity_reg;
    logic             done_reg, done_next;
    logic             ord_ok_reg, ord_ok_next;
    status_t          status_reg, status_next;

    // Payload registers.
    func_t            func_reg, func_next;
    word_t            value_reg, value_next;
    word_t            save_reg, save_next;
    word_t            rv_reg, rv_next;

    // Entry store.
    word_t            mem [DEPTH];
    word_t            rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    word_t            mem_wdata;

    logic [CNT_W-1:0] lo_dec, lo_inc1, top_dec;
    logic [CNT_W:0]   lo_inc;
    logic             lo_below_hi;
    logic             full;

    // Shared signed comparator.
    word_t            cmp_lhs, cmp_rhs;
    logic             cmp_gt;

    assign lo_dec      = lo_reg - CNT_W'(1);
    assign lo_inc1     = lo_reg + CNT_W'(1);
    assign top_dec     = top_reg - CNT_W'(1);
    // The lower sweep index is strictly below the upper one (top holds hi + 1).
    assign lo_inc      = {1'b0, lo_reg} + (CNT_W + 1)'(1);
    assign lo_below_hi = lo_inc < {1'b0, top_reg};
    // The effective limit is the smaller of the capacity register and DEPTH.
    assign full        = (CMP_W'(fill_reg) >= CMP_W'(capacity_reg)) ||
                         (fill_reg == CNT_W'(DEPTH));

    // The insert walk compares the entry just read with the new value; the
    // order check compares the previous entry with the one just read.
    assign cmp_lhs = (state_reg == ST_INS_CMP) ? rdata_reg : save_reg;
    assign cmp_rhs = (state_reg == ST_INS_CMP) ? value_reg : rdata_reg;
    assign cmp_gt  = $signed(cmp_lhs) > $signed(cmp_rhs);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        lo_next     = lo_reg;
        top_next    = top_reg;
        done_next   = 1'b0;
        ord_ok_next = ord_ok_reg;
        status_next = status_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        save_next   = save_reg;
        rv_next     = rv_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next   = func;
                    value_next  = value;
                    status_next = STATUS_DONE;
                    rv_next     = '0;
                    ord_ok_next = 1'b1;
                    lo_next     = '0;
                    top_next    = fill_reg;
                    case (func)
                        FUNC_INSERT:
                        begin
                            if (full)
                            begin
                                status_next = STATUS_FULL;
                                state_next  = ST_ORD_RD;
                            end
                            else
                            begin
                                lo_next    = fill_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        FUNC_REVERSE:
                        begin
                            state_next = ST_RV_CHK;
                        end
                        FUNC_PARTITION:
                        begin
                            state_next = ST_P_CHK;
                        end
                        default:
                        begin
                            if (CNT_W'(index) < fill_reg)
                            begin
                                mem_raddr  = index;
                                state_next = ST_RD_CAP;
                            end
                            else
                            begin
                                status_next = STATUS_RANGE;
                                state_next  = ST_ORD_RD;
                            end
                        end
                    endcase
                end
            end

            // Insert: walk down from the tail, moving larger entries up by one.
            ST_INS_RD:
            begin
                if (lo_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = '0;
                    mem_wdata  = value_reg;
                    fill_next  = fill_reg + CNT_W'(1);
                    state_next = ST_ORD_RD;
                end
                else
                begin
                    mem_raddr  = lo_dec[IDX_W-1:0];
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = lo_reg[IDX_W-1:0];
                if (cmp_gt)
                begin
                    mem_wdata  = rdata_reg;
                    lo_next    = lo_dec;
                    state_next = ST_INS_RD;
                end
                else
                begin
                    mem_wdata  = value_reg;
                    fill_next  = fill_reg + CNT_W'(1);
                    lo_next    = '0;
                    state_next = ST_ORD_RD;
                end
            end

            // Reverse: swap the entries at lo and top - 1 until they meet.
            ST_RV_CHK:
            begin
                if (lo_below_hi)
                begin
                    mem_raddr  = lo_reg[IDX_W-1:0];
                    state_next = ST_RV_LO;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = ST_ORD_RD;
                end
            end
            ST_RV_LO:
            begin
                save_next  = rdata_reg;
                mem_raddr  = top_dec[IDX_W-1:0];
                state_next = ST_SW_A;
            end

            // Swap tail shared by reverse and partition: the upper entry is
            // in the read register and the lower one has been saved.
            ST_SW_A:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[IDX_W-1:0];
                mem_wdata  = rdata_reg;
                state_next = ST_SW_B;
            end
            ST_SW_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = top_dec[IDX_W-1:0];
                mem_wdata = save_reg;
                if (func_reg == FUNC_REVERSE)
                begin
                    lo_next    = lo_inc1;
                    top_next   = top_dec;
                    state_next = ST_RV_CHK;
                end
                else
                begin
                    state_next = ST_P_CHK;
                end
            end

            // Partition: lower scan skips negatives, upper scan skips
            // non-negatives, both bounded by the valid entries.
            ST_P_CHK:
            begin
                if (lo_below_hi)
                begin
                    state_next = ST_P_L_RD;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = ST_ORD_RD;
                end
            end
            ST_P_L_RD:
            begin
                if (lo_reg < fill_reg)
                begin
                    mem_raddr  = lo_reg[IDX_W-1:0];
                    state_next = ST_P_L_CMP;
                end
                else
                begin
                    state_next = ST_P_H_RD;
                end
            end
            ST_P_L_CMP:
            begin
                if (rdata_reg[31])
                begin
                    lo_next    = lo_inc1;
                    state_next = ST_P_L_RD;
                end
                else
                begin
                    save_next  = rdata_reg;
                    state_next = ST_P_H_RD;
                end
            end
            ST_P_H_RD:
            begin
                if (top_reg != '0)
                begin
                    mem_raddr  = top_dec[IDX_W-1:0];
                    state_next = ST_P_H_CMP;
                end
                else
                begin
                    state_next = ST_P_CHK;
                end
            end
            ST_P_H_CMP:
            begin
                if (!rdata_reg[31])
                begin
                    top_next   = top_dec;
                    state_next = ST_P_H_RD;
                end
                else if (lo_below_hi)
                begin
                    // Read the upper entry again so that it is still in the
                    // read register when the swap writes it.
                    mem_raddr  = top_dec[IDX_W-1:0];
                    state_next = ST_SW_A;
                end
                else
                begin
                    state_next = ST_P_CHK;
                end
            end

            ST_RD_CAP:
            begin
                rv_next    = rdata_reg;
                lo_next    = '0;
                state_next = ST_ORD_RD;
            end

            // Order check over the valid entries; ends every item.
            ST_ORD_RD:
            begin
                if (lo_reg < fill_reg)
                begin
                    mem_raddr  = lo_reg[IDX_W-1:0];
                    state_next = ST_ORD_CMP;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ORD_CMP:
            begin
                if ((lo_reg != '0) && cmp_gt)
                begin
                    ord_ok_next = 1'b0;
                end
                save_next  = rdata_reg;
                lo_next    = lo_inc1;
                state_next = ST_ORD_RD;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            lo_reg       <= '0;
            top_reg      <= '0;
            capacity_reg <= CAPACITY_RESET;
            done_reg     <= 1'b0;
            ord_ok_reg   <= 1'b1;
            status_reg   <= STATUS_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            lo_reg     <= lo_next;
            top_reg    <= top_next;
            done_reg   <= done_next;
            ord_ok_reg <= ord_ok_next;
            status_reg <= status_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        value_reg <= value_next;
        save_reg  <= save_next;
        rv_reg    <= rv_next;
    end

    // Single-port-read, single-port-write store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign count      = fill_reg;
    assign in_order   = ord_ok_reg;
    assign read_value = rv_reg;
    assign cfg_ready  = 1'b1;

endmodule

/* test/sorted_array_table_ops_checker.sv */
// Checker for the sorted array table: watches the item, result and capacity channels,
// keeps its own copy of the store and compares every result. Depends on sarr_pkg.
module sorted_array_table_ops_checker #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  sarr_pkg::func_t            func,
    input  sarr_pkg::word_t            value,
    input  logic [$clog2(DEPTH)-1:0]   index,
    input  logic                       done,
    input  sarr_pkg::status_t          status,
    input  logic [$clog2(DEPTH+1)-1:0] count,
    input  logic                       in_order,
    input  sarr_pkg::word_t            read_value,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  sarr_pkg::capacity_t        cfg_data,
    output logic                       all_results_in,
    output int                         mismatches
);

    timeunit 1ns;
    timeprecision 1ps;

    import sarr_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    typedef struct packed {
        status_t         status;
        logic [CW-1:0]   count;
        logic            in_order;
        word_t           read_value;
    } table_result_t;

    word_t         table_words [DEPTH];
    int            fill;
    capacity_t     capacity;
    table_result_t pending_results [$];
    table_result_t predicted;
    table_result_t oldest;

    function automatic logic table_sorted();
        for (int k = 1; k < fill; k++)
        begin
            if ($signed(table_words[k-1]) > $signed(table_words[k]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic swap_words(input int a, input int b);
        word_t t;
        t = table_words[a];
        table_words[a] = table_words[b];
        table_words[b] = t;
    endtask

    // Applies one item to the local store and works out the result it must give.
    task automatic apply_table_op(input func_t op, input word_t val,
                                  input logic [IW-1:0] idx, output table_result_t res);
        int limit;
        int pos;
        int lo;
        int hi;
        res = '0;
        res.status = STATUS_DONE;
        limit = (capacity < DEPTH) ? int'(capacity) : DEPTH;
        case (op)
            FUNC_INSERT:
            begin
                if (fill >= limit)
                    res.status = STATUS_FULL;
                else
                begin
                    pos = fill;
                    while (pos > 0 && $signed(table_words[pos-1]) > $signed(val))
                    begin
                        table_words[pos] = table_words[pos-1];
                        pos--;
                    end
                    table_words[pos] = val;
                    fill++;
                end
            end
            FUNC_REVERSE:
            begin
                lo = 0;
                hi = fill - 1;
                while (lo < hi)
                begin
                    swap_words(lo, hi);
                    lo++;
                    hi--;
                end
            end
            FUNC_PARTITION:
            begin
                lo = 0;
                hi = fill - 1;
                while (lo < hi)
                begin
                    while (lo < fill && $signed(table_words[lo]) < 0)
                        lo++;
                    while (hi >= 0 && $signed(table_words[hi]) >= 0)
                        hi--;
                    if (lo < hi)
                        swap_words(lo, hi);
                end
            end
            default:
            begin
                if (idx < fill)
                    res.read_value = table_words[idx];
                else
                    res.status = STATUS_RANGE;
            end
        endcase
        res.count = CW'(fill);
        res.in_order = table_sorted();
    endtask

    // A result leaves in the same cycle that a new item may be taken, so the
    // result is settled first and the new item predicted afterwards.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            capacity = CAPACITY_RESET;
            pending_results.delete();
            mismatches = 0;
            all_results_in <= 1'b1;
        end
        else
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d count %0d",
                           status, count);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, status);
                        mismatches++;
                    end
                    if (count !== oldest.count)
                    begin
                        $error("count: expected %0d, got %0d", oldest.count, count);
                        mismatches++;
                    end
                    if (in_order !== oldest.in_order)
                    begin
                        $error("in_order: expected %0d, got %0d", oldest.in_order, in_order);
                        mismatches++;
                    end
                    if (read_value !== oldest.read_value)
                    begin
                        $error("read_value: expected %0d, got %0d",
                               $signed(oldest.read_value), $signed(read_value));
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (start && !busy)
            begin
                apply_table_op(func, value, index, predicted);
                pending_results.push_back(predicted);
            end
            all_results_in <= (pending_results.size() == 0);
        end
    end

endmodule

/* test/tb_sorted_array_table_ops_unit.sv */
// Testbench top for the sorted array table: drives items and capacity writes and
// gives the verdict. Depends on sarr_pkg, sorted_array_table_ops_unit and the checker.
module tb_sorted_array_table_ops_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import sarr_pkg::*;

    localparam int DEPTH          = 16;
    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    // The limit covers the slowest item (a partition of a full store with many
    // swaps) and any idling of the sender beyond it.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 80;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    func_t                      func;
    word_t                      value;
    logic [$clog2(DEPTH)-1:0]   index;
    logic                       done;
    status_t                    status;
    logic [$clog2(DEPTH+1)-1:0] count;
    logic                       in_order;
    word_t                      read_value;
    logic                       cfg_valid;
    logic                       cfg_ready;
    capacity_t                  cfg_data;

    logic                       all_results_in;
    int                         mismatches;

    // Percentage of cycles in which the sender holds start low.
    int                         idle_pct;
    int                         items_per_op [4];
    int                         capacity_writes;

    always #(CLK_PERIOD / 2) clk = ~clk;

    sorted_array_table_ops_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .value(value),
        .index(index),
        .done(done),
        .status(status),
        .count(count),
        .in_order(in_order),
        .read_value(read_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    sorted_array_table_ops_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .value(value),
        .index(index),
        .done(done),
        .status(status),
        .count(count),
        .in_order(in_order),
        .read_value(read_value),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .all_results_in(all_results_in),
        .mismatches(mismatches)
    );

    // Values weighted towards the signed extremes, zero, minus one and a band of
    // small numbers, so that duplicates and both signs turn up often; the rest are
    // full random words so that every bit is seen at both levels.
    function automatic word_t random_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5:    return word_t'($urandom_range(40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    // Offers one item and returns in the time step of the edge that takes it,
    // with start still high. Each cycle the sender may hold start low, so the
    // gaps land anywhere in the block's busy period, including just as it ends.
    // Only the low bits of the index are driven.
    task automatic send_item(input func_t op, input word_t val, input int idx);
        logic offered;
        func  <= op;
        value <= val;
        index <= idx[$clog2(DEPTH)-1:0];
        do
        begin
            offered = ($urandom_range(99) >= idle_pct);
            start <= offered;
            @(posedge clk);
        end
        while (!(offered && !busy));
        items_per_op[op]++;
    endtask

    // Holds the sender off until every outstanding result has been seen.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (!all_results_in);
    endtask

    // Only ever called with the block idle, straight after a drain.
    task automatic write_capacity(input capacity_t cap);
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        capacity_writes++;
    endtask

    // Random items with the operations weighted towards insert and read. Now and
    // then the sender stops until the block has caught up completely.
    task automatic random_items(input int n);
        int    pick;
        func_t op;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
                op = FUNC_INSERT;
            else if (pick < 50)
                op = FUNC_REVERSE;
            else if (pick < 65)
                op = FUNC_PARTITION;
            else
                op = FUNC_READ;
            send_item(op, random_word(), $urandom_range(DEPTH - 1));
            if ($urandom_range(299) == 0)
                wait_drained();
        end
    endtask

    // Watchdog: ends the run if no handshake of any kind happens for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        // Capacity, sender idling and item count for each random phase. The
        // fill count never falls, so the capacities mostly rise to let the
        // store be seen at many sizes before it is full for good.
        int phase_cap  [6] = '{10, 12, 13, 16, 31, 16};
        int phase_idle [6] = '{0, 76, 17, 0, 76, 17};
        int phase_len  [6] = '{150, 250, 200, 250, 300, 280};

        idle_pct        = 0;
        capacity_writes = 0;
        items_per_op    = '{default: 0};
        rst_n     <= 1'b0;
        start     <= 1'b0;
        func      <= FUNC_INSERT;
        value     <= '0;
        index     <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= CAPACITY_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset capacity. The empty store first, then a
        // single entry, then the signed extremes, zero, minus one and a
        // duplicate, reads at the edges of the valid range and at the top
        // index, and reverse and partition on a store that is out of order.
        send_item(FUNC_READ, $urandom, 0);
        send_item(FUNC_REVERSE, $urandom, $urandom);
        send_item(FUNC_PARTITION, $urandom, $urandom);
        send_item(FUNC_INSERT, 32'h7FFF_FFFF, $urandom);
        send_item(FUNC_REVERSE, $urandom, $urandom);
        send_item(FUNC_PARTITION, $urandom, $urandom);
        send_item(FUNC_INSERT, 32'h8000_0000, $urandom);
        send_item(FUNC_INSERT, 32'h0000_0000, $urandom);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, $urandom);
        send_item(FUNC_INSERT, 32'h0000_0001, $urandom);
        send_item(FUNC_INSERT, 32'h0000_0000, $urandom);
        send_item(FUNC_READ, $urandom, 0);
        send_item(FUNC_READ, $urandom, 5);
        send_item(FUNC_READ, $urandom, 6);
        send_item(FUNC_READ, $urandom, DEPTH - 1);
        send_item(FUNC_REVERSE, $urandom, $urandom);
        send_item(FUNC_READ, $urandom, 0);
        send_item(FUNC_PARTITION, $urandom, $urandom);
        send_item(FUNC_READ, $urandom, 0);
        send_item(FUNC_READ, $urandom, 5);
        send_item(FUNC_INSERT, 32'h0000_0005, $urandom);
        send_item(FUNC_PARTITION, $urandom, $urandom);
        wait_drained();

        // A capacity of zero refuses every insert; a capacity lowered below
        // the count refuses them too but keeps what is already held.
        write_capacity(5'd0);
        send_item(FUNC_INSERT, random_word(), $urandom);
        send_item(FUNC_READ, $urandom, 6);
        wait_drained();
        write_capacity(5'd3);
        send_item(FUNC_INSERT, random_word(), $urandom);
        send_item(FUNC_READ, $urandom, 0);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_capacity(capacity_t'(phase_cap[p]));
            idle_pct = phase_idle[p];
            random_items(phase_len[p]);
            wait_drained();
        end

        // Give the block time to show any stray result before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d reverses, %0d partitions and %0d reads",
                 items_per_op[FUNC_INSERT], items_per_op[FUNC_REVERSE],
                 items_per_op[FUNC_PARTITION], items_per_op[FUNC_READ]);
        $display("over %0d capacity writes with the sender idle 0, 17 and 76 per cent",
                 capacity_writes);
        if (mismatches == 0 && all_results_in)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
